>>> sv/rlbd_pkg.sv
// Shared types and constants for the run-length byte decoder.
// No dependencies; imported by the controller, datapath and top level.
package rlbd_pkg;

  localparam int BYTE_W    = 8;
  localparam int MAX_LANES = 8;
  localparam int DATA_W    = BYTE_W * MAX_LANES;
  localparam int CNT_W     = 4;
  localparam int LANES_DEF = 8;

  // control byte decoding
  localparam logic [BYTE_W-1:0] RUN_BIAS = 8'd3;
  localparam logic [BYTE_W-1:0] LIT_BIAS = 8'd1;

  // stream phase; the unused code decodes as a control byte
  typedef enum logic [1:0] {
    PH_CTRL = 2'd0,
    PH_RUN  = 2'd1,
    PH_LIT  = 2'd2
  } phase_t;

  // controller state
  typedef enum logic {
    ST_IN  = 1'b0,
    ST_RUN = 1'b1
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic take_ctrl;  // decode a control byte
    logic take_lit;   // pass one literal byte out
    logic take_run;   // capture the run value
    logic emit_run;   // emit one run beat
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    phase_t phase;
    logic   out_free;  // output register can load this cycle
    logic   run_last;  // next run beat is the final one
  } sts_t;

endpackage

>>> sv/rlbd_ctrl.sv
// Controller state machine for the run-length byte decoder.
// Depends on rlbd_pkg; drives the datapath through cmd_t, reads sts_t.
module rlbd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  rlbd_pkg::sts_t  sts,
  output rlbd_pkg::cmd_t  cmd
);
  import rlbd_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IN: begin
        s_tready = sts.out_free;
        if (s_tvalid && sts.out_free) begin
          case (sts.phase)
            PH_RUN: begin
              cmd.take_run = 1'b1;
              state_next   = ST_RUN;
            end
            PH_LIT:  cmd.take_lit  = 1'b1;
            default: cmd.take_ctrl = 1'b1;
          endcase
        end
      end
      ST_RUN: begin
        if (sts.out_free) begin
          cmd.emit_run = 1'b1;
          if (sts.run_last) begin
            state_next = ST_IN;
          end
        end
      end
      default: state_next = ST_IN;
    endcase
  end

endmodule

>>> sv/rlbd_datapath.sv
// Datapath for the run-length byte decoder: phase, count, run value, output register.
// Depends on rlbd_pkg; commanded by rlbd_ctrl.
module rlbd_datapath #(
  parameter int LANES = rlbd_pkg::LANES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [rlbd_pkg::BYTE_W-1:0] s_byte,
  input  rlbd_pkg::cmd_t              cmd,
  output rlbd_pkg::sts_t              sts,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [rlbd_pkg::DATA_W-1:0] m_data,
  output logic [rlbd_pkg::CNT_W-1:0]  m_count,
  output logic                        m_tlast
);
  import rlbd_pkg::*;

  localparam logic [CNT_W-1:0] LANES_C = CNT_W'(LANES);

  phase_t             phase;
  logic [BYTE_W-1:0]  remaining;
  logic [BYTE_W-1:0]  run_byte;

  logic               run_last;
  logic [CNT_W-1:0]   run_cnt;
  logic [DATA_W-1:0]  run_data;
  logic               out_free;

  assign run_last = remaining <= BYTE_W'(LANES_C);
  assign run_cnt  = run_last ? remaining[CNT_W-1:0] : LANES_C;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    for (int i = 0; i < MAX_LANES; i++) begin
      run_data[i*BYTE_W +: BYTE_W] = (CNT_W'(i) < run_cnt) ? run_byte : '0;
    end
  end

  assign sts.phase    = phase;
  assign sts.out_free = out_free;
  assign sts.run_last = run_last;

  // phase and count
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_CTRL;
      remaining <= '0;
    end else if (cmd.take_ctrl) begin
      if (s_byte[BYTE_W-1]) begin
        remaining <= {1'b0, s_byte[BYTE_W-2:0]} + RUN_BIAS;
        phase     <= PH_RUN;
      end else begin
        remaining <= s_byte + LIT_BIAS;
        phase     <= PH_LIT;
      end
    end else if (cmd.take_lit) begin
      remaining <= remaining - LIT_BIAS;
      if (remaining == LIT_BIAS) begin
        phase <= PH_CTRL;
      end
    end else if (cmd.emit_run) begin
      remaining <= remaining - BYTE_W'(run_cnt);
      if (run_last) begin
        phase <= PH_CTRL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_run) begin
      run_byte <= s_byte;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.take_lit || cmd.emit_run) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_lit) begin
      m_data  <= DATA_W'(s_byte);
      m_count <= CNT_W'(1);
      m_tlast <= 1'b1;
    end else if (cmd.emit_run) begin
      m_data  <= run_data;
      m_count <= run_cnt;
      m_tlast <= run_last;
    end
  end

endmodule

>>> sv/run_length_byte_decoder_core.sv
// Top level of the run-length byte decoder.
// Depends on rlbd_pkg, rlbd_ctrl and rlbd_datapath.
//
// Decodes a PackBits-style byte stream, one coded byte per input beat. A control
// byte of 128 or more makes the next byte repeat (control - 128) + 3 times; a
// control byte below 128 makes the next (control + 1) bytes pass as literals.
// Control bytes produce no output. Each literal gives one output beat of one
// lane; a run value gives ceil(run length / LANES) beats, all full except maybe
// the last, with tlast on the final beat of that input byte. Control and literal
// bytes can stream back to back while the output side keeps up (a single
// output register decouples the two sides). For a run value, input stalls
// while the controller steps the run counter one beat per cycle through the
// output register whenever it is free; output backpressure stalls both the
// input and the run beats.
module run_length_byte_decoder_core #(
  parameter int LANES = rlbd_pkg::LANES_DEF  // byte lanes per output beat, 1..8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [63:0] out_data, [67:64] out_valid_count, [71:68] zero
  output logic        m_tlast    // out_last
);
  import rlbd_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [DATA_W-1:0] beat_data;
  logic [CNT_W-1:0]  beat_count;

  rlbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rlbd_datapath #(
    .LANES (LANES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_byte   (s_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_data   (beat_data),
    .m_count  (beat_count),
    .m_tlast  (m_tlast)
  );

  // pack the beat: data low, lane count above, zero pad to a byte boundary
  assign m_tdata = {4'b0000, beat_count, beat_data};

endmodule
